>>> hw/rtl/jos_pkg.sv
// Shared constants, types and helpers for the JSON object splitter.
// No dependencies; compile first.
package jos_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int DEPTH_BITS  = 16;
    localparam int MSG_BITS    = 32;

    typedef logic [7:0]                    char_t;
    typedef logic [OFFSET_BITS-1:0]        offset_t;
    typedef logic signed [DEPTH_BITS-1:0]  depth_t;
    typedef logic [MSG_BITS-1:0]           msg_off_t;

    localparam offset_t OFFSET_MAX = '1;
    localparam depth_t  DEPTH_MAX  = depth_t'({1'b0, {(DEPTH_BITS-1){1'b1}}});
    localparam depth_t  DEPTH_MIN  = depth_t'({1'b1, {(DEPTH_BITS-1){1'b0}}});

    localparam char_t CH_LBRACKET  = 8'h5B;
    localparam char_t CH_RBRACKET  = 8'h5D;
    localparam char_t CH_LBRACE    = 8'h7B;
    localparam char_t CH_RBRACE    = 8'h7D;
    localparam char_t CH_QUOTE     = 8'h22;
    localparam char_t CH_BACKSLASH = 8'h5C;
    localparam char_t CH_SPACE     = 8'h20;
    localparam char_t CH_TAB       = 8'h09;
    localparam char_t CH_CR        = 8'h0D;
    localparam char_t CH_LF        = 8'h0A;

    function automatic logic is_space(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

>>> hw/rtl/jos_feed_if.sv
// Input channel of the splitter: one feed byte per word.
// Depends on jos_pkg.
interface jos_feed_if;
    logic           valid;
    logic           ready;
    jos_pkg::char_t data_byte;
    logic           feed_start;

    modport source (output valid, output data_byte, output feed_start, input ready);
    modport sink   (input valid, input data_byte, input feed_start, output ready);
endinterface

>>> hw/rtl/jos_frame_if.sv
// Output channel of the splitter: one object frame (start, end offsets) per word.
// Depends on jos_pkg.
interface jos_frame_if;
    logic              valid;
    logic              ready;
    jos_pkg::msg_off_t msg_start;
    jos_pkg::msg_off_t msg_end;

    modport source (output valid, output msg_start, output msg_end, input ready);
    modport sink   (input valid, input msg_start, input msg_end, output ready);
endinterface

>>> hw/rtl/json_object_splitter.sv
// Top level of the JSON top-level object framer.
// Depends on jos_pkg, jos_feed_if and jos_frame_if.
//
// Usage:
//   feed   - valid/ready channel, one byte of JSON text per word. Set
//            feed_start on the first byte of a new feed; it clears all scan
//            state before that byte is scanned.
//   frames - valid/ready channel, one word per top-level object: the byte
//            offsets of its opening and matching closing brace (inclusive).
//   If the first non-whitespace byte of a feed is '[', objects are framed one
//   level in; otherwise at depth zero. Braces inside strings are ignored,
//   backslash escapes included. Depth and offset counters saturate.
// Order: an accepted byte waits in the input register until it is scanned, and a
//   frame that it closes is loaded into the result register by that scan.
// Throughput: one byte per cycle unless frames is stalled with a word shown; the
//   scan state update is a single register stage fed from the input register.
// Reset: rst_n clears the scan state and both stage valids; the block then
//   behaves as if a feed started at offset zero.
// Stall: while frames is stalled with a word shown, the input register still
//   fills once, then feed.ready drops until the frame is taken.
module json_object_splitter (
    input  logic        clk,
    input  logic        rst_n,
    jos_feed_if.sink    feed,
    jos_frame_if.source frames
);
    import jos_pkg::*;

    // input register
    logic    s1_valid_reg, s1_valid_next;
    char_t   s1_byte_reg;
    logic    s1_start_reg;

    // scan state
    depth_t  depth_reg, depth_next;
    logic    in_str_reg, in_str_next;
    logic    esc_reg, esc_next;
    offset_t open_off_reg, open_off_next;
    logic    open_vld_reg, open_vld_next;
    logic    decided_reg, decided_next;
    logic    wrapped_reg, wrapped_next;
    offset_t pos_reg, pos_next;

    // result register
    logic     out_valid_reg;
    msg_off_t msg_start_reg;
    msg_off_t msg_end_reg;

    // working values
    depth_t  depth_cur, depth_dec, base;
    logic    in_str_cur, esc_cur, open_vld_cur, decided_cur, wrapped_cur;
    offset_t open_off_cur, pos;
    logic    result;

    logic out_space, s1_adv, in_fire;

    assign out_space   = !out_valid_reg || frames.ready;
    assign s1_adv      = s1_valid_reg && out_space;
    assign feed.ready  = !s1_valid_reg || out_space;
    assign in_fire     = feed.valid && feed.ready;
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_adv);

    assign frames.valid     = out_valid_reg;
    assign frames.msg_start = msg_start_reg;
    assign frames.msg_end   = msg_end_reg;

    // Scan one byte against the current state.
    always_comb
    begin
        // feed_start clears the state before the byte is scanned
        if (s1_start_reg)
        begin
            depth_cur    = '0;
            in_str_cur   = 1'b0;
            esc_cur      = 1'b0;
            open_off_cur = '0;
            open_vld_cur = 1'b0;
            decided_cur  = 1'b0;
            wrapped_cur  = 1'b0;
            pos          = '0;
        end
        else
        begin
            depth_cur    = depth_reg;
            in_str_cur   = in_str_reg;
            esc_cur      = esc_reg;
            open_off_cur = open_off_reg;
            open_vld_cur = open_vld_reg;
            decided_cur  = decided_reg;
            wrapped_cur  = wrapped_reg;
            pos          = pos_reg;
        end

        decided_next = decided_cur;
        wrapped_next = wrapped_cur;
        // first non-whitespace byte picks the framing depth
        if (!decided_cur && !is_space(s1_byte_reg))
        begin
            decided_next = 1'b1;
            wrapped_next = (s1_byte_reg == CH_LBRACKET);
        end
        base = wrapped_next ? depth_t'(1) : '0;

        depth_next    = depth_cur;
        in_str_next   = in_str_cur;
        esc_next      = esc_cur;
        open_off_next = open_off_cur;
        open_vld_next = open_vld_cur;
        result        = 1'b0;
        depth_dec     = (depth_cur != DEPTH_MIN) ? depth_cur - depth_t'(1) : depth_cur;

        if (in_str_cur)
        begin
            if (esc_cur)
                esc_next = 1'b0;
            else if (s1_byte_reg == CH_BACKSLASH)
                esc_next = 1'b1;
            else if (s1_byte_reg == CH_QUOTE)
                in_str_next = 1'b0;
        end
        else if (s1_byte_reg == CH_QUOTE)
        begin
            in_str_next = 1'b1;
        end
        else if (s1_byte_reg == CH_LBRACE || s1_byte_reg == CH_LBRACKET)
        begin
            if (s1_byte_reg == CH_LBRACE && depth_cur == base && !open_vld_cur)
            begin
                open_off_next = pos;
                open_vld_next = 1'b1;
            end
            if (depth_cur != DEPTH_MAX)
                depth_next = depth_cur + depth_t'(1);
        end
        else if (s1_byte_reg == CH_RBRACE || s1_byte_reg == CH_RBRACKET)
        begin
            depth_next = depth_dec;
            if (s1_byte_reg == CH_RBRACE && depth_dec == base && open_vld_cur)
            begin
                open_vld_next = 1'b0;
                result        = 1'b1;
            end
        end

        // hold the offset at all-ones once it gets there
        pos_next = (pos != OFFSET_MAX) ? pos + offset_t'(1) : pos;
    end

    // Input register: load on accept, hold while the scan stage stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= feed.data_byte;
            s1_start_reg <= feed.feed_start;
        end
    end

    // Scan state: advance once per scanned byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= '0;
            in_str_reg   <= 1'b0;
            esc_reg      <= 1'b0;
            open_off_reg <= '0;
            open_vld_reg <= 1'b0;
            decided_reg  <= 1'b0;
            wrapped_reg  <= 1'b0;
            pos_reg      <= '0;
        end
        else if (s1_adv)
        begin
            depth_reg    <= depth_next;
            in_str_reg   <= in_str_next;
            esc_reg      <= esc_next;
            open_off_reg <= open_off_next;
            open_vld_reg <= open_vld_next;
            decided_reg  <= decided_next;
            wrapped_reg  <= wrapped_next;
            pos_reg      <= pos_next;
        end
    end

    // Result register: load a frame, drop it once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && result)
            out_valid_reg <= 1'b1;
        else if (frames.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && result)
        begin
            msg_start_reg <= MSG_BITS'(open_off_cur);
            msg_end_reg   <= MSG_BITS'(pos);
        end
    end

    // An escape can only be pending inside a string.
    a_esc_in_str: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> in_str_reg)
        else $error("escape pending outside a string");

    // An open object implies the framing depth was already decided.
    a_open_decided: assert property (@(posedge clk) disable iff (!rst_n)
        open_vld_reg |-> decided_reg)
        else $error("object open before framing depth decided");

    // Emitting a frame closes the object.
    a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && result) |=> (!open_vld_reg && out_valid_reg))
        else $error("frame emitted without closing the object");

    // Offset steps by one per scanned byte within a feed until it saturates.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_start_reg && pos_reg != OFFSET_MAX)
        |=> pos_reg == $past(pos_reg) + offset_t'(1))
        else $error("byte offset did not advance by one");

endmodule

>>> tb/jos_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for json_object_splitter: watches the feed and frame channels,
// predicts the frame words from the accepted feed bytes and compares them.
// Depends on jos_pkg, jos_feed_if and jos_frame_if.
module jos_frame_checker (
    input  logic clk,
    input  logic rst_n,
    jos_feed_if  feed,
    jos_frame_if frames,
    output int   fail_count,
    output int   frames_pending
);
    import jos_pkg::*;

    typedef struct packed {
        msg_off_t start_off;
        msg_off_t end_off;
    } frame_t;

    frame_t  frames_due[$];

    depth_t  depth_now;
    logic    in_quote;
    logic    escape_next;
    offset_t open_at;
    logic    object_open;
    logic    base_known;
    logic    wrapped;
    offset_t next_offset;

    initial fail_count = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_scan();
        depth_now   = '0;
        in_quote    = 1'b0;
        escape_next = 1'b0;
        open_at     = '0;
        object_open = 1'b0;
        base_known  = 1'b0;
        wrapped     = 1'b0;
        next_offset = '0;
    endtask

    // Advance the scan state by one feed byte; queue a frame if it closes one.
    task automatic scan_byte(input char_t c, input logic fresh_feed);
        offset_t pos;
        depth_t  base;
        frame_t  fr;
        if (fresh_feed)
            clear_scan();
        pos = next_offset;
        if (!base_known && !(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF))
        begin
            base_known = 1'b1;
            wrapped    = (c == CH_LBRACKET);
        end
        base = wrapped ? depth_t'(1) : depth_t'(0);
        if (in_quote)
        begin
            if (escape_next)
                escape_next = 1'b0;
            else if (c == CH_BACKSLASH)
                escape_next = 1'b1;
            else if (c == CH_QUOTE)
                in_quote = 1'b0;
        end
        else if (c == CH_QUOTE)
            in_quote = 1'b1;
        else if (c == CH_LBRACE || c == CH_LBRACKET)
        begin
            if (c == CH_LBRACE && depth_now == base && !object_open)
            begin
                open_at     = pos;
                object_open = 1'b1;
            end
            if (depth_now != DEPTH_MAX)
                depth_now = depth_now + depth_t'(1);
        end
        else if (c == CH_RBRACE || c == CH_RBRACKET)
        begin
            if (depth_now != DEPTH_MIN)
                depth_now = depth_now - depth_t'(1);
            if (c == CH_RBRACE && depth_now == base && object_open)
            begin
                fr.start_off = msg_off_t'(open_at);
                fr.end_off   = msg_off_t'(pos);
                frames_due   = {frames_due, fr};
                object_open  = 1'b0;
            end
        end
        if (pos != OFFSET_MAX)
            next_offset = pos + offset_t'(1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            clear_scan();
            frames_due.delete();
            frames_pending <= 0;
        end
        else
        begin
            if (frames.valid && frames.ready)
            begin
                if (frames_due.size() == 0)
                    report_mismatch($sformatf("unexpected frame start=%0d end=%0d",
                                              frames.msg_start, frames.msg_end));
                else
                begin
                    want = frames_due.pop_front();
                    if (frames.msg_start !== want.start_off)
                        report_mismatch($sformatf("msg_start got %0d want %0d",
                                                  frames.msg_start, want.start_off));
                    if (frames.msg_end !== want.end_off)
                        report_mismatch($sformatf("msg_end got %0d want %0d",
                                                  frames.msg_end, want.end_off));
                end
            end
            if (feed.valid && feed.ready)
                scan_byte(feed.data_byte, feed.feed_start);
            frames_pending <= frames_due.size();
        end
    end

endmodule

>>> tb/tb_json_object_splitter.sv
`timescale 1ns / 1ps
// Testbench top for json_object_splitter: builds JSON byte feeds, drives the
// feed channel, stalls the frame channel and gives the verdict.
// Depends on jos_pkg, jos_feed_if, jos_frame_if and jos_frame_checker.
module tb_json_object_splitter;
    import jos_pkg::*;

    localparam int RANDOM_WORDS   = 1300;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int CALM_WORDS     = 250;   // stretch with no idling on either side
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on any channel
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        char_t c;
        logic  fresh;
    } feed_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   fail_count;
    int   frames_pending;

    // Stimulus shared state: the byte stream to send, and handshake knobs.
    feed_word_t feed_words[$];
    bit         fresh_pending = 1'b0;
    bit         calm          = 1'b0;
    int         holds_asked   = 0;
    int         holds_done    = 0;
    int         quiet_cycles  = 0;

    jos_feed_if  feed ();
    jos_frame_if frames ();

    json_object_splitter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .frames (frames)
    );

    jos_frame_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .feed           (feed),
        .frames         (frames),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Feed builders. Every byte goes through add_char, which tags the first
    // byte of a new feed with feed_start when one was asked for.
    // ------------------------------------------------------------------
    task automatic add_char(input char_t c);
        feed_word_t w;
        w.c           = c;
        w.fresh       = fresh_pending;
        feed_words    = {feed_words, w};
        fresh_pending = 1'b0;
    endtask

    function automatic char_t pick_bracket();
        case ($urandom_range(3))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_LBRACKET;
            default: return CH_RBRACKET;
        endcase
    endfunction

    // Whitespace between tokens, all four blank characters.
    task automatic add_blanks(input int most);
        repeat ($urandom_range(most))
        begin
            case ($urandom_range(3))
                0:       add_char(CH_SPACE);
                1:       add_char(CH_TAB);
                2:       add_char(CH_CR);
                default: add_char(CH_LF);
            endcase
        end
    endtask

    // String with braces, brackets and escapes inside; none of them may
    // move the depth. Escaped quotes are favored since they must not end it.
    task automatic add_string();
        int    r;
        char_t c;
        add_char(CH_QUOTE);
        repeat ($urandom_range(6))
        begin
            r = $urandom_range(99);
            if (r < 25)
            begin
                add_char(CH_BACKSLASH);
                add_char($urandom_range(1) ? CH_QUOTE : char_t'($urandom_range(255)));
            end
            else if (r < 45)
                add_char(pick_bracket());
            else
            begin
                c = char_t'($urandom_range(255));
                if (c == CH_QUOTE || c == CH_BACKSLASH)
                    c = 8'h61;
                add_char(c);
            end
        end
        add_char(CH_QUOTE);
    endtask

    // One object with random nesting and content; cut short unless whole.
    task automatic add_object(input bit whole);
        char_t closers[$];
        int    steps;
        int    cut;
        int    r;
        string filler = "0123456789:,-.eEtrufalsn ";
        cut   = whole ? 1000 : $urandom_range(1, 8);
        steps = 0;
        add_char(CH_LBRACE);
        closers = {closers, CH_RBRACE};
        while (closers.size() != 0 && steps < cut)
        begin
            r = $urandom_range(99);
            if (r < 15 && closers.size() < 4)
            begin
                if (r < 8)
                begin
                    add_char(CH_LBRACE);
                    closers = {closers, CH_RBRACE};
                end
                else
                begin
                    add_char(CH_LBRACKET);
                    closers = {closers, CH_RBRACKET};
                end
            end
            else if (r < 40 || steps > 14)
                add_char(closers.pop_back());
            else if (r < 65)
                add_string();
            else
                add_char(char_t'(filler[$urandom_range(filler.len() - 1)]));
            steps++;
        end
    endtask

    // One random feed: mostly well-formed (array-wrapped or bare objects one after
    // another), some broken ones and some raw noise.
    task automatic add_feed();
        int r;
        int n;
        fresh_pending = ($urandom_range(9) != 0);
        add_blanks(3);
        r = $urandom_range(99);
        n = $urandom_range(1, 4);
        if (r < 45)
        begin
            add_char(CH_LBRACKET);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    add_char(8'h2C);
                add_blanks(2);
                if ($urandom_range(99) < 15)
                    add_string();
                else
                    add_object(1'b1);
            end
            add_blanks(2);
            add_char(CH_RBRACKET);
        end
        else if (r < 80)
        begin
            if ($urandom_range(9) == 0)
                add_string();
            for (int i = 0; i < n; i++)
            begin
                add_object(1'b1);
                add_blanks(2);
            end
        end
        else if (r < 90)
        begin
            // Stray closer first, then a good object, then a truncated one.
            add_char($urandom_range(1) ? CH_RBRACE : CH_RBRACKET);
            add_object(1'b1);
            add_object(1'b0);
        end
        else
        begin
            repeat ($urandom_range(5, 30))
                add_char(char_t'($urandom_range(255)));
        end
    endtask

    // Directed feeds: bytes before any feed_start, leading blanks and an
    // array wrapper, braces and an escaped quote inside a string, unbalanced
    // closers, then the byte extremes.
    task automatic add_directed();
        add_char(CH_LBRACE);
        add_char(CH_RBRACE);

        fresh_pending = 1'b1;
        add_char(CH_SPACE);
        add_char(CH_TAB);
        add_char(CH_CR);
        add_char(CH_LF);
        add_char(CH_LBRACKET);
        add_char(CH_LBRACE);
        add_char(CH_QUOTE);
        add_char(CH_RBRACE);
        add_char(CH_BACKSLASH);
        add_char(CH_QUOTE);
        add_char(CH_QUOTE);
        add_char(CH_RBRACE);
        add_char(CH_RBRACKET);

        fresh_pending = 1'b1;
        add_char(CH_RBRACE);
        add_char(CH_RBRACKET);
        add_char(CH_LBRACKET);
        add_char(CH_LBRACKET);
        add_char(CH_LBRACE);
        add_char(CH_RBRACE);

        fresh_pending = 1'b1;
        add_char(8'hFF);
        add_char(CH_LBRACE);
        add_char(8'h00);
        add_char(CH_RBRACE);
    endtask

    // Offer one word and hold it until the block takes it; idle first at
    // random unless in the calm stretch.
    task automatic send_word(input feed_word_t w);
        while (!calm && $urandom_range(99) < 8)
        begin
            feed.valid <= 1'b0;
            @(posedge clk);
        end
        feed.valid      <= 1'b1;
        feed.data_byte  <= w.c;
        feed.feed_start <= w.fresh;
        @(posedge clk);
        while (!feed.ready)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus and verdict.
    // ------------------------------------------------------------------
    initial
    begin
        int random_first;
        int total;
        feed.valid      <= 1'b0;
        feed.data_byte  <= '0;
        feed.feed_start <= 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        add_directed();
        random_first = feed_words.size();
        while (feed_words.size() < random_first + RANDOM_WORDS)
            add_feed();
        total = feed_words.size();

        for (int i = 0; i < total; i++)
        begin
            // Ask for the long hold-off a third into the random part, and
            // drop all idling for a stretch past the middle.
            if (i == random_first + RANDOM_WORDS / 3)
                holds_asked++;
            calm = (i >= random_first + RANDOM_WORDS / 2) &&
                   (i < random_first + RANDOM_WORDS / 2 + CALM_WORDS);
            send_word(feed_words[i]);
        end
        feed.valid <= 1'b0;

        do
            @(posedge clk);
        while (frames_pending != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0 && frames_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Frame receiver: random stalls, plus a counted hold-off on request.
    initial
    begin
        forever
        begin
            if (holds_done != holds_asked)
            begin
                frames.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                holds_done++;
            end
            else
            begin
                frames.ready <= calm || ($urandom_range(99) >= 8);
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (feed.valid && feed.ready) || (frames.valid && frames.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT: no progress for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
